// ===== sv/rgb_pwm_led_rainbow_driver_defines.svh =====
// assertion macros for the rgb pwm led rainbow driver
`ifndef RGB_PWM_LED_RAINBOW_DRIVER_DEFINES_SVH
`define RGB_PWM_LED_RAINBOW_DRIVER_DEFINES_SVH

`ifndef ASSERT_OFF
`define CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_ALWAYS(lbl, prop, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/rgbpwm_pkg.sv =====
// shared constants, codes and helpers for the rgb pwm led rainbow driver
package rgbpwm_pkg;

    localparam int CNT_W    = 16;
    localparam int PERIOD_W = 16;
    localparam int LVL_W    = 8;
    localparam int SCL_W    = CNT_W + LVL_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20000);
    localparam logic [LVL_W-1:0]    LVL_FULL     = LVL_W'(255);
    localparam logic [LVL_W-1:0]    LVL_ZERO     = '0;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_SET     = 2'd1;
    localparam logic [1:0] MODE_RAINBOW = 2'd2;

    localparam logic [2:0] PH_NONE    = 3'd0;
    localparam logic [2:0] PH_RED     = 3'd1;
    localparam logic [2:0] PH_YELLOW  = 3'd2;
    localparam logic [2:0] PH_GREEN   = 3'd3;
    localparam logic [2:0] PH_CYAN    = 3'd4;
    localparam logic [2:0] PH_BLUE    = 3'd5;
    localparam logic [2:0] PH_MAGENTA = 3'd6;

    typedef logic [LVL_W-1:0] level_t;

    function automatic logic [CNT_W-1:0] counter_top(input logic [PERIOD_W-1:0] p);
        logic [CNT_W+PERIOD_W-1:0] pw;
        logic [CNT_W+PERIOD_W-1:0] mx;
        pw = (CNT_W+PERIOD_W)'(p);
        mx = (CNT_W+PERIOD_W)'({CNT_W{1'b1}});
        return (pw < mx) ? CNT_W'(pw) : CNT_W'(mx);
    endfunction

endpackage

// ===== sv/rgb_pwm_led_rainbow_driver.sv =====
// three-channel pwm led driver with rainbow fade, top level
// Takes one item per clock while the receiver takes results (out_ready): mode 0 is one
// timer tick, mode 1 loads new red/green/blue levels, mode 2 starts the rainbow fade.
// Every item yields exactly one result, carried from the input register to the result
// register that presents it, and items may follow back to back while results are taken.
// Each channel goes dark when the period
// counter reaches floor(top * level / 255); the product top * level is kept in a
// register per channel and refreshed whenever a level or pwm_period changes, and the
// counter is tracked alongside as counter * 255, so the per-tick check is two compares.
// pwm_period (cfg_we/cfg_wdata) must only be written while no item is in flight.
`include "rgb_pwm_led_rainbow_driver_defines.svh"

module rgb_pwm_led_rainbow_driver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  red_level,
    input  logic [7:0]  green_level,
    input  logic [7:0]  blue_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        red_lit,
    output logic        green_lit,
    output logic        blue_lit,
    output logic        period_end,
    output logic [2:0]  fade_phase
);

    localparam int CNT_W = rgbpwm_pkg::CNT_W;
    localparam int SCL_W = rgbpwm_pkg::SCL_W;

    // input register
    logic                  s1_valid_reg;
    logic [1:0]            s1_mode_reg;
    rgbpwm_pkg::level_t    s1_lvl_reg [3];

    // result register
    logic                  out_valid_reg;
    logic [2:0]            out_lit_reg;
    logic                  out_pend_reg;
    logic [2:0]            out_phase_reg;

    // block state
    logic [15:0]           period_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SCL_W-1:0]      scl_reg, scl_next;
    rgbpwm_pkg::level_t    lvl_reg [3];
    rgbpwm_pkg::level_t    lvl_next [3];
    logic [2:0]            lit_reg, lit_next;
    logic                  act_reg, act_next;
    logic [2:0]            phase_reg, phase_next;
    rgbpwm_pkg::level_t    rb_reg [3];
    rgbpwm_pkg::level_t    rb_next [3];
    logic [SCL_W-1:0]      prod_reg [3];
    logic [SCL_W-1:0]      prod_next [3];

    logic                  adv;
    logic                  fire;
    logic                  pend;
    logic                  show;
    rgbpwm_pkg::level_t    show_lvl [3];
    logic [CNT_W-1:0]      top;
    logic [CNT_W-1:0]      top_next;
    logic [SCL_W:0]        lo_bound;
    logic [SCL_W:0]        hi_bound;
    logic [2:0]            hit;

    assign adv      = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && adv;
    assign in_ready = !s1_valid_reg || adv;

    assign top      = rgbpwm_pkg::counter_top(period_reg);
    assign top_next = cfg_we ? rgbpwm_pkg::counter_top(cfg_wdata) : top;

    // compare hit when 255*(cnt+1) <= top*level < 255*(cnt+2)
    assign lo_bound = {1'b0, scl_reg} + (SCL_W+1)'(255);
    assign hi_bound = {1'b0, scl_reg} + (SCL_W+1)'(510);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hit[i] = (lo_bound <= {1'b0, prod_reg[i]}) && ({1'b0, prod_reg[i]} < hi_bound)
                     && (lvl_reg[i] != rgbpwm_pkg::LVL_ZERO)
                     && (lvl_reg[i] != rgbpwm_pkg::LVL_FULL);
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        scl_next   = scl_reg;
        lvl_next   = lvl_reg;
        lit_next   = lit_reg;
        act_next   = act_reg;
        phase_next = phase_reg;
        rb_next    = rb_reg;
        pend       = 1'b0;
        show       = 1'b0;
        show_lvl   = lvl_reg;
        if (fire)
        begin
            unique case (s1_mode_reg)
                rgbpwm_pkg::MODE_TICK:
                begin
                    if (cnt_reg >= top)
                    begin
                        pend     = 1'b1;
                        cnt_next = '0;
                        scl_next = '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            lit_next[i] = (lvl_reg[i] != rgbpwm_pkg::LVL_ZERO);
                        end
                        if (act_reg)
                        begin
                            unique case (phase_reg)
                                rgbpwm_pkg::PH_RED:
                                begin
                                    show = 1'b1;
                                    show_lvl[0] = rgbpwm_pkg::LVL_FULL;
                                    show_lvl[2] = rgbpwm_pkg::LVL_ZERO;
                                    if (rb_reg[1] != rgbpwm_pkg::LVL_FULL)
                                    begin
                                        rb_next[1]  = rb_reg[1] + 8'd1;
                                        show_lvl[1] = rb_reg[1] + 8'd1;
                                    end
                                    else
                                    begin
                                        phase_next  = rgbpwm_pkg::PH_YELLOW;
                                        show_lvl[1] = rgbpwm_pkg::LVL_FULL;
                                    end
                                end
                                rgbpwm_pkg::PH_YELLOW:
                                begin
                                    show = 1'b1;
                                    show_lvl[1] = rgbpwm_pkg::LVL_FULL;
                                    show_lvl[2] = rgbpwm_pkg::LVL_ZERO;
                                    if (rb_reg[0] != rgbpwm_pkg::LVL_ZERO)
                                    begin
                                        rb_next[0]  = rb_reg[0] - 8'd1;
                                        show_lvl[0] = rb_reg[0] - 8'd1;
                                    end
                                    else
                                    begin
                                        phase_next  = rgbpwm_pkg::PH_GREEN;
                                        show_lvl[0] = rgbpwm_pkg::LVL_ZERO;
                                    end
                                end
                                rgbpwm_pkg::PH_GREEN:
                                begin
                                    show = 1'b1;
                                    show_lvl[0] = rgbpwm_pkg::LVL_ZERO;
                                    show_lvl[1] = rgbpwm_pkg::LVL_FULL;
                                    if (rb_reg[2] != rgbpwm_pkg::LVL_FULL)
                                    begin
                                        rb_next[2]  = rb_reg[2] + 8'd1;
                                        show_lvl[2] = rb_reg[2] + 8'd1;
                                    end
                                    else
                                    begin
                                        phase_next  = rgbpwm_pkg::PH_CYAN;
                                        show_lvl[2] = rgbpwm_pkg::LVL_FULL;
                                    end
                                end
                                rgbpwm_pkg::PH_CYAN:
                                begin
                                    show = 1'b1;
                                    show_lvl[0] = rgbpwm_pkg::LVL_ZERO;
                                    show_lvl[2] = rgbpwm_pkg::LVL_FULL;
                                    if (rb_reg[1] != rgbpwm_pkg::LVL_ZERO)
                                    begin
                                        rb_next[1]  = rb_reg[1] - 8'd1;
                                        show_lvl[1] = rb_reg[1] - 8'd1;
                                    end
                                    else
                                    begin
                                        phase_next  = rgbpwm_pkg::PH_BLUE;
                                        show_lvl[1] = rgbpwm_pkg::LVL_ZERO;
                                    end
                                end
                                rgbpwm_pkg::PH_BLUE:
                                begin
                                    show = 1'b1;
                                    show_lvl[1] = rgbpwm_pkg::LVL_ZERO;
                                    show_lvl[2] = rgbpwm_pkg::LVL_FULL;
                                    if (rb_reg[0] != rgbpwm_pkg::LVL_FULL)
                                    begin
                                        rb_next[0]  = rb_reg[0] + 8'd1;
                                        show_lvl[0] = rb_reg[0] + 8'd1;
                                    end
                                    else
                                    begin
                                        phase_next  = rgbpwm_pkg::PH_MAGENTA;
                                        show_lvl[0] = rgbpwm_pkg::LVL_FULL;
                                    end
                                end
                                rgbpwm_pkg::PH_MAGENTA:
                                begin
                                    show = 1'b1;
                                    show_lvl[0] = rgbpwm_pkg::LVL_FULL;
                                    show_lvl[1] = rgbpwm_pkg::LVL_ZERO;
                                    if (rb_reg[2] != rgbpwm_pkg::LVL_ZERO)
                                    begin
                                        rb_next[2]  = rb_reg[2] - 8'd1;
                                        show_lvl[2] = rb_reg[2] - 8'd1;
                                    end
                                    else
                                    begin
                                        phase_next  = rgbpwm_pkg::PH_RED;
                                        show_lvl[2] = rgbpwm_pkg::LVL_ZERO;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        scl_next = scl_reg + SCL_W'(255);
                        for (int i = 0; i < 3; i++)
                        begin
                            if (hit[i])
                            begin
                                lit_next[i] = 1'b0;
                            end
                        end
                    end
                end
                rgbpwm_pkg::MODE_SET:
                begin
                    show     = 1'b1;
                    show_lvl = s1_lvl_reg;
                end
                rgbpwm_pkg::MODE_RAINBOW:
                begin
                    act_next    = 1'b1;
                    phase_next  = rgbpwm_pkg::PH_RED;
                    rb_next[0]  = rgbpwm_pkg::LVL_FULL;
                    rb_next[1]  = rgbpwm_pkg::LVL_ZERO;
                    rb_next[2]  = rgbpwm_pkg::LVL_ZERO;
                    show        = 1'b1;
                    show_lvl[0] = rgbpwm_pkg::LVL_FULL;
                    show_lvl[1] = rgbpwm_pkg::LVL_ZERO;
                    show_lvl[2] = rgbpwm_pkg::LVL_ZERO;
                end
                default:
                begin
                end
            endcase
        end
        if (show)
        begin
            lvl_next = show_lvl;
            cnt_next = '0;
            scl_next = '0;
            for (int i = 0; i < 3; i++)
            begin
                lit_next[i] = (show_lvl[i] != rgbpwm_pkg::LVL_ZERO);
            end
        end
    end

    // top*level per channel, kept in step with levels and pwm_period
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = SCL_W'(top_next) * SCL_W'(lvl_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg    <= rgbpwm_pkg::PERIOD_RESET;
            cnt_reg       <= '0;
            scl_reg       <= '0;
            lit_reg       <= '0;
            act_reg       <= 1'b0;
            phase_reg     <= rgbpwm_pkg::PH_NONE;
            for (int i = 0; i < 3; i++)
            begin
                lvl_reg[i]  <= '0;
                rb_reg[i]   <= '0;
                prod_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            cnt_reg   <= cnt_next;
            scl_reg   <= scl_next;
            lit_reg   <= lit_next;
            act_reg   <= act_next;
            phase_reg <= phase_next;
            lvl_reg   <= lvl_next;
            rb_reg    <= rb_next;
            prod_reg  <= prod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg   <= mode;
            s1_lvl_reg[0] <= red_level;
            s1_lvl_reg[1] <= green_level;
            s1_lvl_reg[2] <= blue_level;
        end
        if (fire)
        begin
            out_lit_reg   <= lit_next;
            out_pend_reg  <= pend;
            out_phase_reg <= phase_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_lit    = out_lit_reg[0];
    assign green_lit  = out_lit_reg[1];
    assign blue_lit   = out_lit_reg[2];
    assign period_end = out_pend_reg;
    assign fade_phase = out_phase_reg;

    `CHK_ALWAYS(a_prod_red, prod_reg[0] == SCL_W'(top) * SCL_W'(lvl_reg[0]), "red product stale")
    `CHK_ALWAYS(a_prod_blue, prod_reg[2] == SCL_W'(top) * SCL_W'(lvl_reg[2]), "blue product stale")
    `CHK_ALWAYS(a_scaled_cnt, scl_reg == SCL_W'(cnt_reg) * SCL_W'(255), "scaled counter off")
    `CHK_ALWAYS(a_phase_act, act_reg == (phase_reg != rgbpwm_pkg::PH_NONE), "phase vs active")
    `CHK_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg, "result dropped")

endmodule

// ===== bench/led_pwm_checker.sv =====
// checker for the rgb pwm led driver: predicts every result item and compares it
`timescale 1ns / 1ps

module led_pwm_checker
    import rgbpwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  mode,
    input  level_t      red_level,
    input  level_t      green_level,
    input  level_t      blue_level,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        red_lit,
    input  logic        green_lit,
    input  logic        blue_lit,
    input  logic        period_end,
    input  logic [2:0]  fade_phase,
    output int          errors,
    output int          pending,
    output int          n_items,
    output int          n_results,
    output int          n_wraps,
    output logic [5:0]  phases_seen
);

    typedef struct packed
    {
        logic       red;
        logic       green;
        logic       blue;
        logic       wrap;
        logic [2:0] phase;
    } lamp_t;

    logic [PERIOD_W-1:0] period_reg;
    logic [CNT_W-1:0]    count;
    level_t              shown [3];
    logic [2:0]          lit;
    logic                fading;
    logic [2:0]          phase;
    level_t              fade_lv [3];
    lamp_t               lamp_q [$];

    int         err_cnt;
    int         item_cnt;
    int         result_cnt;
    int         wrap_cnt;
    logic [5:0] seen;
    lamp_t      want;
    lamp_t      got;

    task automatic show_colour(input level_t r, input level_t g, input level_t b);
        shown[0] = r;
        shown[1] = g;
        shown[2] = b;
        count = '0;
        for (int i = 0; i < 3; i++)
            lit[i] = (shown[i] != LVL_ZERO);
    endtask

    task automatic fade_step();
        case (phase)
            PH_RED:
                if (fade_lv[1] != LVL_FULL)
                begin
                    fade_lv[1] = fade_lv[1] + 1'b1;
                    show_colour(LVL_FULL, fade_lv[1], LVL_ZERO);
                end
                else
                begin
                    phase = PH_YELLOW;
                    show_colour(LVL_FULL, LVL_FULL, LVL_ZERO);
                end
            PH_YELLOW:
                if (fade_lv[0] != LVL_ZERO)
                begin
                    fade_lv[0] = fade_lv[0] - 1'b1;
                    show_colour(fade_lv[0], LVL_FULL, LVL_ZERO);
                end
                else
                begin
                    phase = PH_GREEN;
                    show_colour(LVL_ZERO, LVL_FULL, LVL_ZERO);
                end
            PH_GREEN:
                if (fade_lv[2] != LVL_FULL)
                begin
                    fade_lv[2] = fade_lv[2] + 1'b1;
                    show_colour(LVL_ZERO, LVL_FULL, fade_lv[2]);
                end
                else
                begin
                    phase = PH_CYAN;
                    show_colour(LVL_ZERO, LVL_FULL, LVL_FULL);
                end
            PH_CYAN:
                if (fade_lv[1] != LVL_ZERO)
                begin
                    fade_lv[1] = fade_lv[1] - 1'b1;
                    show_colour(LVL_ZERO, fade_lv[1], LVL_FULL);
                end
                else
                begin
                    phase = PH_BLUE;
                    show_colour(LVL_ZERO, LVL_ZERO, LVL_FULL);
                end
            PH_BLUE:
                if (fade_lv[0] != LVL_FULL)
                begin
                    fade_lv[0] = fade_lv[0] + 1'b1;
                    show_colour(fade_lv[0], LVL_ZERO, LVL_FULL);
                end
                else
                begin
                    phase = PH_MAGENTA;
                    show_colour(LVL_FULL, LVL_ZERO, LVL_FULL);
                end
            PH_MAGENTA:
                if (fade_lv[2] != LVL_ZERO)
                begin
                    fade_lv[2] = fade_lv[2] - 1'b1;
                    show_colour(LVL_FULL, LVL_ZERO, fade_lv[2]);
                end
                else
                begin
                    phase = PH_RED;
                    show_colour(LVL_FULL, LVL_ZERO, LVL_ZERO);
                end
            default:
                ;
        endcase
    endtask

    task automatic timer_tick(output logic wrap);
        logic [CNT_W-1:0] top;
        logic [SCL_W-1:0] cmp;
        // counter and register are equally wide, so the top is the register itself
        top = period_reg;
        wrap = 1'b0;
        if (count >= top)
        begin
            count = '0;
            for (int i = 0; i < 3; i++)
                lit[i] = (shown[i] != LVL_ZERO);
            if (fading)
                fade_step();
            wrap = 1'b1;
        end
        else
        begin
            count = count + 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                if (shown[i] != LVL_ZERO && shown[i] != LVL_FULL)
                begin
                    cmp = (SCL_W'(top) * SCL_W'(shown[i])) / SCL_W'(LVL_FULL);
                    if (cmp == SCL_W'(count))
                        lit[i] = 1'b0;
                end
            end
        end
    endtask

    task automatic advance_lamps(input logic [1:0] m, input level_t r, input level_t g,
                                 input level_t b, output lamp_t res);
        logic wrap;
        wrap = 1'b0;
        case (m)
            MODE_TICK:
                timer_tick(wrap);
            MODE_SET:
                show_colour(r, g, b);
            MODE_RAINBOW:
            begin
                fading = 1'b1;
                phase = PH_RED;
                fade_lv[0] = LVL_FULL;
                fade_lv[1] = LVL_ZERO;
                fade_lv[2] = LVL_ZERO;
                show_colour(LVL_FULL, LVL_ZERO, LVL_ZERO);
            end
            default:
                ;
        endcase
        res.red = lit[0];
        res.green = lit[1];
        res.blue = lit[2];
        res.wrap = wrap;
        res.phase = phase;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg = PERIOD_RESET;
            count = '0;
            lit = '0;
            fading = 1'b0;
            phase = PH_NONE;
            for (int i = 0; i < 3; i++)
            begin
                shown[i] = LVL_ZERO;
                fade_lv[i] = LVL_ZERO;
            end
            lamp_q.delete();
            err_cnt = 0;
            item_cnt = 0;
            result_cnt = 0;
            wrap_cnt = 0;
            seen = '0;
        end
        else
        begin
            if (cfg_we)
                period_reg = cfg_wdata;
            if (out_valid && out_ready)
            begin
                result_cnt++;
                got = {red_lit, green_lit, blue_lit, period_end, fade_phase};
                if (lamp_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result item with nothing expected: r%b g%b b%b end%b ph%0d",
                                 $time, got.red, got.green, got.blue, got.wrap, got.phase);
                end
                else
                begin
                    want = lamp_q.pop_front();
                    if (got !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"%0t: mismatch expected r%b g%b b%b end%b ph%0d,",
                                      " got r%b g%b b%b end%b ph%0d"}, $time,
                                     want.red, want.green, want.blue, want.wrap, want.phase,
                                     got.red, got.green, got.blue, got.wrap, got.phase);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                advance_lamps(mode, red_level, green_level, blue_level, want);
                lamp_q.push_back(want);
                item_cnt++;
                if (want.wrap)
                    wrap_cnt++;
                if (want.phase != PH_NONE)
                    seen[want.phase - 3'd1] = 1'b1;
            end
        end
        errors <= err_cnt;
        pending <= lamp_q.size();
        n_items <= item_cnt;
        n_results <= result_cnt;
        n_wraps <= wrap_cnt;
        phases_seen <= seen;
    end

endmodule

// ===== bench/tb.sv =====
// testbench top for the rgb pwm led driver: stimulus, pacing and verdict
`timescale 1ns / 1ps

module tb;
    import rgbpwm_pkg::*;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         HOLD_CYCLES    = 80;
    localparam int         SETTLE_CYCLES  = 6;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [15:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] mode;
    level_t     red_level;
    level_t     green_level;
    level_t     blue_level;
    logic       out_valid;
    logic       out_ready;
    logic       red_lit;
    logic       green_lit;
    logic       blue_lit;
    logic       period_end;
    logic [2:0] fade_phase;

    int         errors;
    int         pending;
    int         n_items;
    int         n_results;
    int         n_wraps;
    logic [5:0] phases_seen;

    int tx_idle_pct = 27;
    int rx_idle_pct = 58;
    int hold_reqs = 0;
    int hold_seen;
    int n_settings = 0;
    int stall;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rgb_pwm_led_rainbow_driver DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_lit     (red_lit),
        .green_lit   (green_lit),
        .blue_lit    (blue_lit),
        .period_end  (period_end),
        .fade_phase  (fade_phase)
    );

    led_pwm_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_lit     (red_lit),
        .green_lit   (green_lit),
        .blue_lit    (blue_lit),
        .period_end  (period_end),
        .fade_phase  (fade_phase),
        .errors      (errors),
        .pending     (pending),
        .n_items     (n_items),
        .n_results   (n_results),
        .n_wraps     (n_wraps),
        .phases_seen (phases_seen)
    );

    function automatic level_t pick_level();
        case ($urandom_range(9))
            0: return LVL_ZERO;
            1: return LVL_FULL;
            2: return level_t'(1);
            3: return level_t'(254);
            default: return level_t'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input logic [1:0] m, input level_t r, input level_t g,
                             input level_t b);
        logic ok;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        red_level <= r;
        green_level <= g;
        blue_level <= b;
        do
        begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end
        while (!ok);
    endtask

    task automatic random_items(input int count, input int tick_pct);
        logic [1:0] m;
        int roll;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < tick_pct)
                m = MODE_TICK;
            else
            begin
                roll = $urandom_range(99);
                if (roll < 55)
                    m = MODE_SET;
                else if (roll < 75)
                    m = MODE_RAINBOW;
                else
                    m = MODE_UNUSED;
            end
            send_item(m, pick_level(), pick_level(), pick_level());
        end
    endtask

    task automatic ticks(input int count);
        repeat (count)
            send_item(MODE_TICK, pick_level(), pick_level(), pick_level());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_period(input logic [15:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
        n_settings++;
    endtask

    // receiver side: random ready, long hold when requested
    initial
    begin
        out_ready = 1'b0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        stall = 0;
        while (stall < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall = 0;
            else
                stall++;
        end
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        mode = MODE_TICK;
        red_level = LVL_ZERO;
        green_level = LVL_ZERO;
        blue_level = LVL_ZERO;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        random_items(40, 97);

        // top of 2: level 1 compares to 0 and stays lit all period
        write_period(16'd2);
        send_item(MODE_UNUSED, level_t'(8'hA5), level_t'(8'h5A), LVL_FULL);
        send_item(MODE_SET, LVL_FULL, LVL_ZERO, level_t'(128));
        ticks(4);
        send_item(MODE_SET, level_t'(1), level_t'(254), LVL_ZERO);
        ticks(3);
        send_item(MODE_RAINBOW, LVL_ZERO, LVL_ZERO, LVL_ZERO);
        ticks(6);
        send_item(MODE_SET, LVL_ZERO, LVL_ZERO, LVL_ZERO);
        ticks(3);
        send_item(MODE_UNUSED, LVL_ZERO, LVL_FULL, LVL_ZERO);
        send_item(MODE_SET, LVL_FULL, LVL_FULL, LVL_FULL);
        ticks(1);

        write_period(16'd255);
        random_items(150, 97);

        tx_idle_pct = 58;
        rx_idle_pct = 27;
        write_period(16'hFFFF);
        random_items(60, 90);
        write_period(16'd7);
        random_items(80, 85);
        hold_reqs <= hold_reqs + 1;
        tx_idle_pct = 0;
        ticks(30);
        tx_idle_pct = 58;
        drain();
        random_items(80, 85);

        // top of 0 wraps every tick, so the fade moves one step per tick
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_period(16'd0);
        send_item(MODE_RAINBOW, pick_level(), pick_level(), pick_level());
        repeat (680)
            send_item(($urandom_range(49) == 0) ? MODE_SET : MODE_TICK,
                      pick_level(), pick_level(), pick_level());
        write_period(16'd1);
        random_items(100, 80);
        drain();

        $display("run covered %0d items, %0d results, %0d period settings",
                 n_items, n_results, n_settings);
        $display("period ends seen %0d, fade phases reached %b, mismatches %0d",
                 n_wraps, phases_seen, errors);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
